/* hdl/heq_pkg.sv */
// Package for the histogram equalizer: widths, sizes, state and op codes.
// No dependencies.
`default_nettype none
package heq_pkg;
    localparam int COUNT_BITS = 21;
    localparam int LEVELS     = 256;
    localparam int LVL_BITS   = 8;
    localparam int CHANNELS   = 3;
    localparam int TBL_DEPTH  = CHANNELS * LEVELS;
    localparam int ADDR_BITS  = 10;
    localparam logic [COUNT_BITS-1:0] MAX_PIXELS = {COUNT_BITS{1'b1}};
    localparam int QUO_BITS   = COUNT_BITS + 8;

    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_MAP   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC,
        ST_BUILD_RD,
        ST_BUILD_DIV,
        ST_MAP_RD,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

/* hdl/heq_if.sv */
// Valid/ready channel interfaces for the histogram equalizer.
// Depends on nothing.
`default_nettype none
interface heq_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] chan_a;
    logic [7:0] chan_b;
    logic [7:0] chan_c;
    modport source (output valid, operation, chan_a, chan_b, chan_c, input ready);
    modport sink   (input valid, operation, chan_a, chan_b, chan_c, output ready);
endinterface

interface heq_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] mapped_a;
    logic [7:0] mapped_b;
    logic [7:0] mapped_c;
    modport source (output valid, mapped_a, mapped_b, mapped_c, input ready);
    modport sink   (input valid, mapped_a, mapped_b, mapped_c, output ready);
endinterface
`default_nettype wire

/* hdl/histogram_equalizer_top.sv */
// Top level of the 8-bit histogram equalizer.
// Depends on heq_pkg, heq_if, heq_ram and heq_div.
//
// Use: one input channel (in_ch) carries words with an operation bit and three
// 8-bit channel values; one output channel (out_ch) returns one word per map
// operation. cfg_we/cfg_wdata write colour_mode (0 grey, 1 per-channel RGB);
// the user must do so only while the block is idle; the block does not enforce it.
// Accumulate words add each channel value to its own 256-bin histogram held
// in one 768 x COUNT_BITS RAM, and count the pixel. Each bin is read, then
// written back plus one, through the RAM's read and write ports.
// The first map word after accumulation builds the 768-entry table: each
// entry takes a read of the histogram RAM and a bit-serial divide. Each map
// word then reads the table RAM once per channel and loads the output
// register; no new word is taken until the result has left that register.
// An accumulate after mapping starts a new frame with a clearing pass over the
// histogram RAM. Reset also runs that clearing pass (no input taken; colour_mode
// writes still land).
// If the receiver stalls, the result is held in the output register and no
// new word is taken until it leaves.
`default_nettype none
module histogram_equalizer_top (
    input  wire        clk,
    input  wire        rst_n,
    heq_in_if.sink     in_ch,
    heq_out_if.source  out_ch,
    input  wire        cfg_we,
    input  wire        cfg_wdata
);
    localparam int CB = heq_pkg::COUNT_BITS;
    localparam int AB = heq_pkg::ADDR_BITS;
    localparam int QB = heq_pkg::QUO_BITS;

    heq_pkg::state_t state_reg, state_next;

    logic                 mode_reg;
    logic                 phase_reg, phase_next;
    logic                 clr_frame_reg, clr_frame_next;
    logic [CB-1:0]        total_reg, total_next;
    logic [AB-1:0]        addr_reg, addr_next;
    logic [1:0]           ch_reg, ch_next;
    logic [CB-1:0]        cum_reg, cum_next;
    logic [7:0]           a_reg, b_reg, c_reg;
    logic [7:0]           oa_reg, oa_next, ob_reg, ob_next, oc_reg, oc_next;
    logic                 ovalid_reg, ovalid_next;
    logic                 step_reg, step_next;

    // histogram RAM ports
    logic                 h_we;
    logic [AB-1:0]        h_waddr, h_raddr;
    logic [CB-1:0]        h_wdata, h_rdata;
    // table RAM ports
    logic                 t_we;
    logic [AB-1:0]        t_waddr, t_raddr;
    logic [7:0]           t_wdata, t_rdata;
    // divider
    logic                 d_start, d_done;
    logic [QB-1:0]        d_num, d_quo;
    logic [CB-1:0]        cum_sum;

    logic [7:0] cur_val;

    heq_ram #(.WIDTH(CB), .DEPTH(heq_pkg::TBL_DEPTH)) u_hist (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    heq_ram #(.WIDTH(8), .DEPTH(heq_pkg::TBL_DEPTH)) u_tbl (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    heq_div u_div (
        .clk(clk), .rst_n(rst_n), .start(d_start), .num(d_num),
        .den(total_reg), .done(d_done), .quo(d_quo)
    );

    always_comb
    begin
        unique case (ch_reg)
            2'd0:    cur_val = a_reg;
            2'd1:    cur_val = b_reg;
            default: cur_val = c_reg;
        endcase
    end

    // cumulative count never exceeds the total, so it fits in CB bits
    assign cum_sum = cum_reg + h_rdata;
    assign d_num   = (QB'(cum_sum) << 8) - QB'(cum_sum);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        clr_frame_next = clr_frame_reg;
        total_next     = total_reg;
        addr_next      = addr_reg;
        ch_next        = ch_reg;
        cum_next       = cum_reg;
        oa_next        = oa_reg;
        ob_next        = ob_reg;
        oc_next        = oc_reg;
        ovalid_next    = ovalid_reg;
        step_next      = step_reg;
        h_we           = 1'b0;
        h_waddr        = addr_reg;
        h_wdata        = '0;
        h_raddr        = addr_reg;
        t_we           = 1'b0;
        t_waddr        = addr_reg;
        t_wdata        = 8'(d_quo);
        t_raddr        = {ch_reg, cur_val};
        d_start        = 1'b0;
        in_ch.ready    = 1'b0;

        if (out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            heq_pkg::ST_CLEAR:
            begin
                // sweep zeros through the histogram RAM
                h_we    = 1'b1;
                h_wdata = '0;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == AB'(heq_pkg::TBL_DEPTH - 1))
                begin
                    addr_next = '0;
                    total_next = '0;
                    phase_next = 1'b0;
                    if (clr_frame_reg)
                    begin
                        clr_frame_next = 1'b0;
                        state_next = heq_pkg::ST_ACC;
                    end
                    else
                    begin
                        state_next = heq_pkg::ST_IDLE;
                    end
                    ch_next   = 2'd0;
                    step_next = 1'b0;
                end
            end
            heq_pkg::ST_IDLE:
            begin
                in_ch.ready = !ovalid_reg;
                ch_next   = 2'd0;
                step_next = 1'b0;
                if (in_ch.valid && !ovalid_reg)
                begin
                    if (in_ch.operation == heq_pkg::OP_ACCUM)
                    begin
                        if (phase_reg)
                        begin
                            clr_frame_next = 1'b1;
                            addr_next      = '0;
                            state_next     = heq_pkg::ST_CLEAR;
                        end
                        else
                        begin
                            state_next = heq_pkg::ST_ACC;
                        end
                    end
                    else if (!phase_reg)
                    begin
                        addr_next  = '0;
                        cum_next   = '0;
                        state_next = heq_pkg::ST_BUILD_RD;
                    end
                    else
                    begin
                        state_next = heq_pkg::ST_MAP_RD;
                    end
                end
            end
            heq_pkg::ST_ACC:
            begin
                // read bin, then write it back plus one; per channel
                h_raddr = {ch_reg, cur_val};
                h_waddr = {ch_reg, cur_val};
                if (total_reg == heq_pkg::MAX_PIXELS)
                begin
                    state_next = heq_pkg::ST_IDLE;
                end
                else if (!step_reg)
                begin
                    step_next = 1'b1;
                end
                else
                begin
                    h_we      = 1'b1;
                    h_wdata   = h_rdata + 1'b1;
                    step_next = 1'b0;
                    ch_next   = ch_reg + 1'b1;
                    if (ch_reg == 2'd2)
                    begin
                        total_next = total_reg + 1'b1;
                        state_next = heq_pkg::ST_IDLE;
                    end
                end
            end
            heq_pkg::ST_BUILD_RD:
            begin
                // h_raddr = addr_reg; data valid next cycle
                if (!step_reg)
                begin
                    step_next = 1'b1;
                end
                else
                begin
                    step_next = 1'b0;
                    cum_next  = cum_sum;
                    d_start   = 1'b1;
                    state_next = heq_pkg::ST_BUILD_DIV;
                end
            end
            heq_pkg::ST_BUILD_DIV:
            begin
                if (d_done)
                begin
                    t_we    = 1'b1;
                    t_wdata = (total_reg == '0) ? 8'd0 : 8'(d_quo);
                    addr_next = addr_reg + 1'b1;
                    if (addr_reg[7:0] == 8'hFF)
                    begin
                        cum_next = '0;
                    end
                    if (addr_reg == AB'(heq_pkg::TBL_DEPTH - 1))
                    begin
                        addr_next  = '0;
                        phase_next = 1'b1;
                        ch_next    = 2'd0;
                        state_next = heq_pkg::ST_MAP_RD;
                    end
                    else
                    begin
                        state_next = heq_pkg::ST_BUILD_RD;
                    end
                end
            end
            heq_pkg::ST_MAP_RD:
            begin
                // issue read for channel ch_reg, capture previous channel
                if (step_reg)
                begin
                    unique case (ch_reg)
                        2'd1:    oa_next = t_rdata;
                        2'd2:    ob_next = t_rdata;
                        default: oc_next = t_rdata;
                    endcase
                end
                step_next = 1'b1;
                ch_next   = ch_reg + 1'b1;
                if (ch_reg == 2'd2)
                begin
                    state_next = heq_pkg::ST_OUT;
                end
            end
            heq_pkg::ST_OUT:
            begin
                oc_next     = mode_reg ? t_rdata : 8'd0;
                if (!mode_reg)
                begin
                    ob_next = 8'd0;
                end
                ovalid_next = 1'b1;
                step_next   = 1'b0;
                ch_next     = 2'd0;
                state_next  = heq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = heq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= heq_pkg::ST_CLEAR;
            mode_reg      <= 1'b0;
            phase_reg     <= 1'b0;
            clr_frame_reg <= 1'b0;
            total_reg     <= '0;
            addr_reg      <= '0;
            ch_reg        <= 2'd0;
            step_reg      <= 1'b0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            clr_frame_reg <= clr_frame_next;
            total_reg     <= total_next;
            addr_reg      <= addr_next;
            ch_reg        <= ch_next;
            step_reg      <= step_next;
            ovalid_reg    <= ovalid_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    // hold input word and result payload
    always_ff @(posedge clk)
    begin
        cum_reg <= cum_next;
        oa_reg  <= oa_next;
        ob_reg  <= ob_next;
        oc_reg  <= oc_next;
        if (in_ch.valid && in_ch.ready)
        begin
            a_reg <= in_ch.chan_a;
            b_reg <= in_ch.chan_b;
            c_reg <= in_ch.chan_c;
        end
    end

    assign out_ch.valid    = ovalid_reg;
    assign out_ch.mapped_a = oa_reg;
    assign out_ch.mapped_b = ob_reg;
    assign out_ch.mapped_c = oc_reg;

    // input is only taken in idle with an empty output register
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> (state_reg == heq_pkg::ST_IDLE && !ovalid_reg))
        else $error("input taken outside idle");

    // a result appears only right after the map output step
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(state_reg) == heq_pkg::ST_OUT)
        else $error("result without map");

    // pixel count never passes capacity
    a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
        $past(total_reg) == heq_pkg::MAX_PIXELS && state_reg != heq_pkg::ST_CLEAR
        && $past(state_reg) != heq_pkg::ST_CLEAR |-> total_reg == heq_pkg::MAX_PIXELS)
        else $error("pixel count overflow");
endmodule
`default_nettype wire

/* hdl/heq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module heq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* hdl/heq_div.sv */
// Restoring divider, one quotient bit per cycle: quo = num / den.
// Depends on heq_pkg.
`default_nettype none
module heq_div (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                start,
    input  wire  [heq_pkg::QUO_BITS-1:0]       num,
    input  wire  [heq_pkg::COUNT_BITS-1:0]     den,
    output logic                               done,
    output logic [heq_pkg::QUO_BITS-1:0]       quo
);
    localparam int CNT_BITS = $clog2(heq_pkg::QUO_BITS + 1);

    logic [heq_pkg::QUO_BITS-1:0]   q_reg, q_next;
    logic [heq_pkg::COUNT_BITS:0]   r_reg, r_next;
    logic [CNT_BITS-1:0]            cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [heq_pkg::COUNT_BITS:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[heq_pkg::COUNT_BITS-1:0], q_reg[heq_pkg::QUO_BITS-1]};
        if (start)
        begin
            q_next    = num;
            r_next    = '0;
            cnt_next  = CNT_BITS'(heq_pkg::QUO_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in next numerator bit, subtract when it fits
            if (trial >= {1'b0, den})
            begin
                r_next = trial - {1'b0, den};
                q_next = {q_reg[heq_pkg::QUO_BITS-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[heq_pkg::QUO_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;
endmodule
`default_nettype wire

/* verif/heq_checker.sv */
// Checker for the histogram equalizer: watches both channels and the config port,
// predicts each mapped word and compares. Depends on heq_pkg and heq_if.
`default_nettype none
module heq_checker (
    input  wire         clk,
    input  wire         rst_n,
    heq_in_if           in_ch,
    heq_out_if          out_ch,
    input  wire         cfg_we,
    input  wire         cfg_wdata,
    output int          fail_count,
    output int          pending
);
    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
    } mapped_t;

    logic [heq_pkg::COUNT_BITS-1:0] hist [heq_pkg::CHANNELS][heq_pkg::LEVELS];
    logic [7:0]                     lut  [heq_pkg::CHANNELS][heq_pkg::LEVELS];
    logic [heq_pkg::COUNT_BITS-1:0] npix;
    logic                           mapping;
    logic                           rgb_mode;
    mapped_t                        expected_words [$];

    // Build equalization tables from the current histograms.
    task automatic build_luts();
        longint unsigned cum;
        longint unsigned q;
        for (int ch = 0; ch < heq_pkg::CHANNELS; ch++)
        begin
            cum = 0;
            for (int v = 0; v < heq_pkg::LEVELS; v++)
            begin
                cum += hist[ch][v];
                if (npix == 0)
                    lut[ch][v] = 8'd0;
                else
                begin
                    q = (255 * cum) / npix;
                    lut[ch][v] = (q > 255) ? 8'd255 : q[7:0];
                end
            end
        end
    endtask

    task automatic take_pixel(input logic op, input logic [7:0] a, input logic [7:0] b,
                              input logic [7:0] c);
        mapped_t m;
        if (op == heq_pkg::OP_ACCUM)
        begin
            if (mapping)
            begin
                foreach (hist[i, j]) hist[i][j] = '0;
                npix    = '0;
                mapping = 1'b0;
            end
            if (npix != heq_pkg::MAX_PIXELS)
            begin
                hist[0][a]++;
                hist[1][b]++;
                hist[2][c]++;
                npix++;
            end
        end
        else
        begin
            if (!mapping)
            begin
                build_luts();
                mapping = 1'b1;
            end
            m.a = lut[0][a];
            m.b = rgb_mode ? lut[1][b] : 8'd0;
            m.c = rgb_mode ? lut[2][c] : 8'd0;
            expected_words.push_back(m);
        end
    endtask

    initial
    begin
        foreach (hist[i, j]) hist[i][j] = '0;
        npix       = '0;
        mapping    = 1'b0;
        rgb_mode   = 1'b0;
        fail_count = 0;
    end

    assign pending = expected_words.size();

    always @(posedge clk)
    begin
        mapped_t want;
        if (rst_n)
        begin
            if (cfg_we)
                rgb_mode <= cfg_wdata;
            if (in_ch.valid && in_ch.ready)
                take_pixel(in_ch.operation, in_ch.chan_a, in_ch.chan_b, in_ch.chan_c);
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word actual %h %h %h", $time,
                             out_ch.mapped_a, out_ch.mapped_b, out_ch.mapped_c);
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (want.a !== out_ch.mapped_a || want.b !== out_ch.mapped_b
                        || want.c !== out_ch.mapped_c)
                    begin
                        $display("%0t: mismatch expected %h %h %h actual %h %h %h",
                                 $time, want.a, want.b, want.c,
                                 out_ch.mapped_a, out_ch.mapped_b, out_ch.mapped_c);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

/* verif/testbench.sv */
// Top of the histogram equalizer testbench: clock, reset, stimulus and verdict.
// Depends on heq_pkg, heq_if, heq_checker and histogram_equalizer_top.
`default_nettype none
module testbench;
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    logic quiet = 1'b0;      // no idling in the last part of the run
    int   fail_count;
    int   pending;

    heq_in_if  in_ch ();
    heq_out_if out_ch ();

    histogram_equalizer_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch.sink),
        .out_ch   (out_ch.source),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    heq_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        in_ch.valid     = 1'b0;
        in_ch.operation = heq_pkg::OP_ACCUM;
        in_ch.chan_a    = '0;
        in_ch.chan_b    = '0;
        in_ch.chan_c    = '0;
        out_ch.ready    = 1'b0;
    end

    // Receiver: stall in random bursts, never once quiet.
    always @(posedge clk)
    begin
        int hold;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            hold = $urandom_range(1, 5);
            out_ch.ready <= 1'b0;
            repeat (hold) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
    end

    // Drive one word and hold it until the block takes it; gap at random first.
    task automatic send_word(input logic op, input logic [7:0] a, input logic [7:0] b,
                             input logic [7:0] c);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.chan_a    <= a;
        in_ch.chan_b    <= b;
        in_ch.chan_c    <= c;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Drop valid, drain all expected words, let the block settle, then write mode.
    task automatic set_mode(input logic mode);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One frame: random pixels, a and b skewed to narrow ranges when asked, then a run of map words.
    task automatic random_frame(input int n_acc, input int n_map, input bit skewed);
        logic [7:0] a, b, c;
        for (int i = 0; i < n_acc; i++)
        begin
            a = skewed ? 8'($urandom_range(100, 140)) : 8'($urandom);
            b = skewed ? 8'($urandom_range(0, 30)) : 8'($urandom);
            c = 8'($urandom);
            send_word(heq_pkg::OP_ACCUM, a, b, c);
        end
        for (int i = 0; i < n_map; i++)
            send_word(heq_pkg::OP_MAP, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Map with no pixels: tables all zero.
        set_mode(1'b1);
        send_word(heq_pkg::OP_MAP, 8'h00, 8'hff, 8'h80);
        send_word(heq_pkg::OP_MAP, 8'hff, 8'h00, 8'h01);
        // Extreme levels, then a mode change between passes.
        send_word(heq_pkg::OP_ACCUM, 8'h00, 8'hff, 8'h55);
        send_word(heq_pkg::OP_ACCUM, 8'hff, 8'h00, 8'haa);
        send_word(heq_pkg::OP_ACCUM, 8'h80, 8'h7f, 8'h01);
        set_mode(1'b0);
        send_word(heq_pkg::OP_MAP, 8'h00, 8'hff, 8'h55);
        send_word(heq_pkg::OP_MAP, 8'hff, 8'h00, 8'haa);
        send_word(heq_pkg::OP_MAP, 8'h7f, 8'h80, 8'hfe);
        // Single-pixel frame in colour mode.
        set_mode(1'b1);
        send_word(heq_pkg::OP_ACCUM, 8'h40, 8'h40, 8'h40);
        send_word(heq_pkg::OP_MAP, 8'h3f, 8'h40, 8'hff);
        send_word(heq_pkg::OP_MAP, 8'h00, 8'hff, 8'h41);

        // Random frames; build is slow so keep the number of frames small.
        for (int f = 0; f < 8; f++)
        begin
            if (f == 6)
                quiet <= 1'b1;
            set_mode(1'($urandom_range(0, 1)));
            random_frame($urandom_range(40, 80), $urandom_range(30, 50), f[0]);
        end

        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("testbench NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
hdl/heq_pkg.sv
hdl/heq_if.sv
hdl/heq_ram.sv
hdl/heq_div.sv
hdl/histogram_equalizer_top.sv
verif/heq_checker.sv
verif/testbench.sv
